// File: hdl/ise_pkg.sv
package ise_pkg;

   localparam int KEY_W = 32;

   // signed q16.16 key, compared as a plain two's complement integer
   typedef logic signed [KEY_W-1:0] key_type;

   // per-cycle commands broadcast to every cell of the chain
   typedef struct packed {
      logic insert;     // place the incoming key, larger keys move up one cell
      logic shift_out;  // every cell takes its upper neighbor's key, the top cell keeps its own
   } ctrl_type;

endpackage

// File: hdl/ise_cell.sv
module ise_cell (
   input  logic              clock,
   input  ise_pkg::ctrl_type ctrl,
   input  logic              occupied,
   input  ise_pkg::key_type  new_key,
   input  ise_pkg::key_type  lower_key,
   input  logic              lower_gt,
   input  ise_pkg::key_type  upper_key,
   output ise_pkg::key_type  key_q,
   output logic              gt
);

   ise_pkg::key_type key_ff;
   ise_pkg::key_type key_in;

   // an empty cell counts as larger than any key
   assign gt    = !occupied || (key_ff > new_key);
   assign key_q = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctrl.insert && gt) begin
         key_in = lower_gt ? lower_key : new_key;
      end else if (ctrl.shift_out) begin
         key_in = upper_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// File: hdl/insertion_sort_engine_unit.sv
// channel | ports       | tdata (low bit up)   | tlast     | tuser
// --------+-------------+----------------------+-----------+-----------
// input   | req_t*      | key [31:0]           | batch_end | -
// result  | rsp_t*      | sorted_key [31:0]    | final_res | overflowed
//
// every cell compares an accepted key with its own key at once and
// the chain shifts larger keys up by one cell in the same edge
// after the batch end, n results leave cell 0, one per cycle while ready,
// as the chain shifts down; no key is taken until the last result is gone
// synchronous active-high reset empties the store and clears the overflow flag
// a stalled result holds in cell 0 since the chain only moves on a transaction
module insertion_sort_engine_unit #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key[31:0]
   input  logic        req_tlast,   // batch_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_key[31:0]
   output logic        rsp_tlast,   // final_res
   output logic        rsp_tuser    // overflowed
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // control state
   logic [CNT_W-1:0] fill_ff, fill_in;     // keys held, counts down while draining
   logic             drop_ff, drop_in;     // a key of this batch was lost
   logic             drain_ff, drain_in;   // emitting the sorted run

   logic req_fire;
   logic rsp_fire;
   logic full;

   ise_pkg::ctrl_type ctrl;
   ise_pkg::key_type  new_key;
   ise_pkg::key_type  cell_key [CAPACITY];
   logic              cell_gt  [CAPACITY];

   assign req_tready = !drain_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign full       = (fill_ff == CNT_W'(CAPACITY));
   assign new_key    = $signed(req_tdata);

   assign ctrl.insert    = req_fire && !full;
   assign ctrl.shift_out = rsp_fire;

   // the cell chain: index 0 holds the smallest key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ise_pkg::key_type lower_key;
      logic             lower_gt;
      ise_pkg::key_type upper_key;
      logic             occupied;

      assign occupied = (CNT_W'(i) < fill_ff);

      if (i == 0) begin : g_bottom
         // nothing below cell 0, so a new key lands here when cell 0 is larger
         assign lower_key = new_key;
         assign lower_gt  = 1'b0;
      end else begin : g_mid
         assign lower_key = cell_key[i-1];
         assign lower_gt  = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         // top cell refills with its own key while draining, it is then unused
         assign upper_key = cell_key[i];
      end else begin : g_below_top
         assign upper_key = cell_key[i+1];
      end

      ise_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied),
         .new_key   (new_key),
         .lower_key (lower_key),
         .lower_gt  (lower_gt),
         .upper_key (upper_key),
         .key_q     (cell_key[i]),
         .gt        (cell_gt[i])
      );
   end

   // fill count, overflow flag and drain state
   always_comb begin
      fill_in  = fill_ff;
      drop_in  = drop_ff;
      drain_in = drain_ff;
      if (req_fire) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            fill_in = fill_ff + CNT_W'(1);
         end
         if (req_tlast) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_fire) begin
         fill_in = fill_ff - CNT_W'(1);
         if (fill_ff == CNT_W'(1)) begin
            // last result of the run: store is empty again
            drain_in = 1'b0;
            drop_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
         drain_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
         drain_ff <= drain_in;
      end
   end

   // results come straight from cell 0, which is a register
   assign rsp_tvalid = drain_ff;
   assign rsp_tdata  = cell_key[0];
   assign rsp_tlast  = (fill_ff == CNT_W'(1));
   assign rsp_tuser  = drop_ff;

endmodule

// File: hdl/ise_checker.sv
module ise_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // no key is taken while a run is being emitted, and the block is always ready for one otherwise
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      req_tready != rsp_tvalid)
      else $error("input ready and result valid overlap or both idle");

   // a batch end starts the run on the next cycle
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("batch end not followed by results");

   // the marked result ends the run
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("results continue after the final one");

   // within a run results keep coming and the overflow flag does not change
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && $stable(rsp_tuser)))
      else $error("run broken or overflow flag changed within a run");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind insertion_sort_engine_unit ise_checker u_ise_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: bench/testbench.sv
module testbench;

   localparam int RUN_DEPTH   = 64;
   localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the whole simulation
   localparam int GRACE       = 20;      // results leave one per cycle while ready, right after a batch end

   // one sorted result: sorted_key, final_res, overflowed
   typedef struct packed {
      ise_pkg::key_type key;
      logic             last_flag;
      logic             overflow;
   } run_entry_type;

   // one directed row; a typed row carries the single result it must give
   typedef struct packed {
      ise_pkg::key_type key;
      logic             batch_end;
      logic             typed;
      run_entry_type    want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // key[31:0]
   logic        req_tlast;   // batch_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // sorted_key[31:0]
   logic        rsp_tlast;   // final_res
   logic        rsp_tuser;   // overflowed

   // shadow copy of the sort store
   ise_pkg::key_type sorted_keys [RUN_DEPTH];
   int               held;
   logic             dropped;
   run_entry_type    fresh_run [$];     // results caused by the latest key
   run_entry_type    expected_run [$];  // results still owed by the block

   int          error_count = 0;
   int          cycle_count = 0;
   int          keys_sent;
   int          send_idle_pct;
   int          recv_stall_pct;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // single-key batches: the run is just that key, marked last, no overflow
      '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
      '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
      '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{32'h0001_0000, 1'b1, 1'b1, '{32'h0001_0000, 1'b1, 1'b0}},
      // mixed signs, duplicates and both extremes
      '{32'h0005_0000, 1'b0, 1'b0, '0},
      '{32'hFFFD_0000, 1'b0, 1'b0, '0},
      '{32'h0005_0000, 1'b0, 1'b0, '0},
      '{32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      // descending arrival, every key goes to the bottom
      '{32'h0003_0000, 1'b0, 1'b0, '0},
      '{32'h0002_0000, 1'b0, 1'b0, '0},
      '{32'h0001_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'hFFFF_0000, 1'b1, 1'b0, '0},
      // ascending arrival, every key goes on top
      '{32'h8000_0001, 1'b0, 1'b0, '0},
      '{32'h7FFF_FFFE, 1'b0, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
      // alternating bit patterns
      '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
      '{32'h5555_5555, 1'b1, 1'b0, '0}
   };

   insertion_sort_engine_unit #(
      .CAPACITY(RUN_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_error(string msg);
      $display("ERROR @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // stable insertion: a new key lands above every stored key <= it;
   // a batch end flushes the whole store as one run
   function automatic void absorb_key(ise_pkg::key_type k, logic batch_end);
      int slot;
      fresh_run.delete();
      if (held >= RUN_DEPTH) begin
         dropped = 1'b1;
      end else begin
         slot = held;
         while (slot > 0 && sorted_keys[slot-1] > k) begin
            sorted_keys[slot] = sorted_keys[slot-1];
            slot--;
         end
         sorted_keys[slot] = k;
         held++;
      end
      if (batch_end) begin
         for (int i = 0; i < held; i++)
            fresh_run.push_back(run_entry_type'{sorted_keys[i], (i == held - 1), dropped});
         held    = 0;
         dropped = 1'b0;
      end
   endfunction

   // offer one key, hold it until the transaction, then book its results
   task automatic send_key(ise_pkg::key_type k, logic batch_end, logic typed,
                           run_entry_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= k;
      req_tlast  <= batch_end;
      do @(posedge clock); while (!req_tready);
      keys_sent++;
      absorb_key(k, batch_end);
      if (typed) begin
         expected_run.push_back(want);
      end else begin
         foreach (fresh_run[i]) expected_run.push_back(fresh_run[i]);
      end
   endtask

   // half full-range keys, plus clusters that force duplicates and extremes
   function automatic ise_pkg::key_type pick_key();
      case ($urandom_range(3))
         0:       return ise_pkg::key_type'(($urandom_range(6) - 3) <<< 16);
         1: begin
            case ($urandom_range(4))
               0:       return 32'h8000_0000;
               1:       return 32'h8000_0001;
               2:       return 32'h7FFF_FFFF;
               3:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return ise_pkg::key_type'($urandom);
      endcase
   endfunction

   task automatic send_batch(int size);
      for (int i = 0; i < size; i++)
         send_key(pick_key(), (i == size - 1), 1'b0, '0);
   endtask

   // drop valid and hold off until every owed result has left
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_run.size() != 0);
   endtask

   // receiver: random back-pressure at the current stall rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result monitor: each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_run.size() == 0) begin
            flag_error($sformatf("unexpected result key=%h last=%b over=%b",
                                 rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            if (rsp_tdata !== expected_run[0].key)
               flag_error($sformatf("sorted_key got %h want %h",
                                    rsp_tdata, expected_run[0].key));
            if (rsp_tlast !== expected_run[0].last_flag)
               flag_error($sformatf("final_res got %b want %b (key %h)",
                                    rsp_tlast, expected_run[0].last_flag,
                                    expected_run[0].key));
            if (rsp_tuser !== expected_run[0].overflow)
               flag_error($sformatf("overflowed got %b want %b (key %h)",
                                    rsp_tuser, expected_run[0].overflow,
                                    expected_run[0].key));
            void'(expected_run.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int phase_end;
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tlast      <= 1'b0;
      keys_sent      = 0;
      held           = 0;
      dropped        = 1'b0;
      send_idle_pct  = 25;
      recv_stall_pct = 85;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows, under the first idling pattern
      foreach (directed_rows[r])
         send_key(directed_rows[r].key, directed_rows[r].batch_end,
                  directed_rows[r].typed, directed_rows[r].want);

      // random batches in three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 25; recv_stall_pct = 85; end
            1: begin send_idle_pct = 85; recv_stall_pct = 25; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         phase_end = keys_sent + 90;
         if (phase == 0) begin
            // one past capacity: the batch-end key itself is dropped
            send_batch(RUN_DEPTH + 1);
         end else if (phase == 1) begin
            // exactly full, no overflow; then let the run leave before going on
            send_batch(RUN_DEPTH);
            drain_results();
         end
         while (keys_sent < phase_end) begin
            if ($urandom_range(9) == 0)
               send_batch($urandom_range(RUN_DEPTH - 4, RUN_DEPTH + 8));
            else
               send_batch($urandom_range(1, 12));
         end
      end

      drain_results();
      repeat (GRACE) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
